// ===== src/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, widths and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Default sizes, handed to the top level parameters
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    // Quotient bits resolved by the divide step in one cycle
    localparam int STEP_BITS = 8;

    // Field widths
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    // Radix register reset and saturation limits
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // Digits below this print as '0'..'9', the rest as 'A'..'F'
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = 7'd55;  // 'A' - 10

    // ASCII code of one digit
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        if (d < DECIMAL_LIMIT) begin
            return CHAR_ZERO + CHAR_W'(d);
        end else begin
            return CHAR_ALPHA + CHAR_W'(d);
        end
    endfunction

    // Clamp the radix register to a usable base
    function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end else begin
            return r;
        end
    endfunction

endpackage

// ===== src/rdc_if.sv =====
// ----------------------------------------------------------------------------
// rdc_if
// Valid/ready channels: value requests in, digit requests out.
// ----------------------------------------------------------------------------
interface rdc_in_if #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
    logic                          valid;
    logic                          ready;
    logic [rdc_pkg::DIGIT_W-1:0]   digit;
    logic [rdc_pkg::CHAR_W-1:0]    char_code;
    logic                          last_digit;

    modport source (output valid, output digit, output char_code, output last_digit,
                    input ready);
    modport sink   (input valid, input digit, input char_code, input last_digit,
                    output ready);
endinterface

// ===== src/rdc_div_step.sv =====
// ----------------------------------------------------------------------------
// rdc_div_step
// Restoring divide step: shifts one chunk of dividend bits through the
// running remainder against a small base, giving the quotient chunk.
// ----------------------------------------------------------------------------
module rdc_div_step #(
    parameter int STEP_BITS = rdc_pkg::STEP_BITS
) (
    input  logic [rdc_pkg::RADIX_W-1:0] i_base,
    input  logic [rdc_pkg::DIGIT_W-1:0] i_rem,
    input  logic [STEP_BITS-1:0]        i_chunk,
    output logic [STEP_BITS-1:0]        o_quot,
    output logic [rdc_pkg::DIGIT_W-1:0] o_rem
);
    import rdc_pkg::*;

    // Remainder stays below base (at most 16), so a 5-bit trial suffices
    always_comb begin : div_chain
        logic [RADIX_W-1:0] trial;
        logic [DIGIT_W-1:0] rem;
        rem    = i_rem;
        trial  = '0;
        o_quot = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem, i_chunk[i]};
            if (trial >= i_base) begin
                o_quot[i] = 1'b1;
                rem       = DIGIT_W'(trial - i_base);
            end else begin
                o_quot[i] = 1'b0;
                rem       = trial[DIGIT_W-1:0];
            end
        end
        o_rem = rem;
    end

endmodule

// ===== src/radix_digit_converter_top.sv =====
// Each digit is divided out chunk by chunk (CHUNKS = VALUE_BITS/8 rounded up, 4 at 32 bits)
// on the shared 8-bit-per-cycle divide step, then digits go out one per cycle unless the output stalls.
// Input ready is high only while idle; the last digit may still wait at output.
// Reset (synchronous, active low) clears the sequencer and output valid and
// sets radix to 10; no clearing pass is needed.
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Converts an unsigned value to base 2..16 digits, most significant first,
// by repeated division on one shared divide step and a LIFO of digits.
// ----------------------------------------------------------------------------
module radix_digit_converter_top #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rdc_pkg::RADIX_W-1:0]   i_cfg_wr_data,
    rdc_in_if.sink                        i_req,
    rdc_out_if.source                     o_rsp
);
    import rdc_pkg::*;

    localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W  = CHUNKS * STEP_BITS;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [RADIX_W-1:0]   r_radix;
    logic [WORK_W-1:0]    r_work, n_work;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [CHUNK_W-1:0]   r_chunk, n_chunk;
    logic                 r_nz, n_nz;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [DIGIT_W-1:0]   r_stack [MAX_DIGITS];
    logic [DIGIT_W-1:0]   n_stack [MAX_DIGITS];
    logic                 r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0]   r_out_digit, n_out_digit;
    logic                 r_out_last, n_out_last;

    logic [RADIX_W-1:0]   w_base;
    logic [STEP_BITS-1:0] w_quot;
    logic [DIGIT_W-1:0]   w_rem;
    logic                 w_nz;
    logic                 w_pop;

    assign w_base = eff_base(r_radix);

    // Shared divide step on the top chunk of the working value
    rdc_div_step #(
        .STEP_BITS (STEP_BITS)
    ) u_div_step (
        .i_base  (w_base),
        .i_rem   (r_rem),
        .i_chunk (r_work[WORK_W-1 -: STEP_BITS]),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    assign w_nz  = r_nz | (w_quot != '0);
    assign w_pop = (r_state == ST_EMIT) && (!r_out_valid || o_rsp.ready);

    // Handshake outputs
    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.digit      = r_out_digit;
    assign o_rsp.char_code  = ascii_of(r_out_digit);
    assign o_rsp.last_digit = r_out_last;

    // Sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_nz        = r_nz;
        n_count     = r_count;
        n_stack     = r_stack;
        n_out_valid = r_out_valid;
        n_out_digit = r_out_digit;
        n_out_last  = r_out_last;

        // output register drains independently of the sequencer
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_work  = WORK_W'(i_req.value);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_nz    = 1'b0;
                    n_count = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_work = (r_work << STEP_BITS) | WORK_W'(w_quot);
                if (r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                    // digit done: push remainder, quotient becomes next dividend
                    n_stack[0] = w_rem;
                    for (int i = 1; i < MAX_DIGITS; i++) begin
                        n_stack[i] = r_stack[i-1];
                    end
                    n_count = r_count + CNT_W'(1);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_nz    = 1'b0;
                    if (!w_nz || r_count == CNT_W'(MAX_DIGITS - 1)) begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_chunk = r_chunk + CHUNK_W'(1);
                    n_rem   = w_rem;
                    n_nz    = w_nz;
                end
            end
            ST_EMIT: begin
                if (w_pop) begin
                    // pop most significant digit into the output register
                    n_out_valid = 1'b1;
                    n_out_digit = r_stack[0];
                    n_out_last  = (r_count == CNT_W'(1));
                    for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                        n_stack[i] = r_stack[i+1];
                    end
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_radix     <= RADIX_RESET;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_work      <= n_work;
        r_rem       <= n_rem;
        r_chunk     <= n_chunk;
        r_nz        <= n_nz;
        r_stack     <= n_stack;
        r_out_digit <= n_out_digit;
        r_out_last  <= n_out_last;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radix_digit_converter_top. Values go in on the
// request channel and every digit that comes back is checked field by field
// (digit, ASCII code, last flag) against digits worked out here by repeated
// division in the current base. The bench runs a directed pass over base and
// value extremes, then random values under several radix settings and
// changing handshake idling.
// ----------------------------------------------------------------------------
module tb;
    import rdc_pkg::*;

    localparam int VALUE_W         = 32;
    localparam int DIGITS_MAX      = 32;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 27;
    localparam int IDLE_GAP        = 4;     // cycles of quiet before a radix write
    localparam int SETTLE_CYCLES   = 170;   // room for a full 32-digit value, plus margin
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int MAX_PRINTS      = 40;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
    localparam logic [RADIX_W-1:0] BASE_LO    = 5'd2;
    localparam logic [RADIX_W-1:0] BASE_HI    = 5'd16;

    localparam logic [RADIX_W-1:0] PHASE_RADIX [RANDOM_PHASES] =
        '{5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd10, 5'd7, 5'd1, 5'd17, 5'd8, 5'd5, 5'd13};

    // One digit request as seen on the output channel
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [CHAR_W-1:0]  char_code;
        logic               last_digit;
    } digit_rsp_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [RADIX_W-1:0] cfg_wr_data;

    rdc_in_if #(.VALUE_BITS(VALUE_W)) req_if ();
    rdc_out_if                        rsp_if ();

    logic [VALUE_W-1:0] pending_values[$];
    digit_rsp_t         expected_digits[$];
    logic [RADIX_W-1:0] radix_shadow;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 error_count;
    bit                 hold_armed;
    int                 hold_left;
    int                 stall_cycles;

    radix_digit_converter_top #(
        .VALUE_BITS (VALUE_W),
        .MAX_DIGITS (DIGITS_MAX)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if.sink),
        .o_rsp         (rsp_if.source)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Split a value into digits of the clamped base, queue them MSD first
    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [RADIX_W-1:0] base;
        logic [DIGIT_W-1:0] lsd_first [DIGITS_MAX];
        int                 count;
        digit_rsp_t         rsp;
        if (radix_shadow < BASE_LO) begin
            base = BASE_LO;
        end else if (radix_shadow > BASE_HI) begin
            base = BASE_HI;
        end else begin
            base = radix_shadow;
        end
        rest  = value;
        count = 0;
        do begin
            lsd_first[count] = DIGIT_W'(rest % base);
            rest             = rest / base;
            count++;
        end while (rest != 0 && count < DIGITS_MAX);
        for (int k = count - 1; k >= 0; k--) begin
            rsp.digit      = lsd_first[k];
            rsp.char_code  = (lsd_first[k] < DECIMAL_LIMIT)
                           ? ASCII_ZERO + CHAR_W'(lsd_first[k])
                           : ASCII_A + CHAR_W'(lsd_first[k] - DECIMAL_LIMIT);
            rsp.last_digit = (k == 0);
            expected_digits.push_back(rsp);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return $urandom >> $urandom_range(1, 31);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS) begin
            $display("tb: mismatch at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    // Sampled at falling edges, clear of the clocked processes
    task automatic wait_drained();
        while (pending_values.size() != 0 || req_if.valid || expected_digits.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Radix writes only once the block has gone quiet
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_drained();
        repeat (IDLE_GAP) @(negedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        radix_shadow = r;
        @(negedge clk);
    endtask

    // Request driver: valid holds until accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_digits(req_if.value);
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_values.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_if.valid <= 1'b1;
                    req_if.value <= pending_values.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Digit monitor and receiver back-pressure
    always @(posedge clk) begin : digit_monitor
        digit_rsp_t want;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_digits.size() == 0) begin
                    report_mismatch($sformatf("digit %0d arrived with none expected",
                                              rsp_if.digit));
                end else begin
                    want = expected_digits.pop_front();
                    if (rsp_if.digit !== want.digit) begin
                        report_mismatch($sformatf("digit %0d, expected %0d",
                                                  rsp_if.digit, want.digit));
                    end
                    if (rsp_if.char_code !== want.char_code) begin
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  rsp_if.char_code, want.char_code));
                    end
                    if (rsp_if.last_digit !== want.last_digit) begin
                        report_mismatch($sformatf("last_digit %0b, expected %0b",
                                                  rsp_if.last_digit, want.last_digit));
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_armed) begin
                hold_armed   <= 1'b0;
                hold_left    <= HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        req_if.valid  = 1'b0;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        radix_shadow  = RADIX_RESET;
        hold_armed    = 1'b0;
        hold_left     = 0;
        stall_cycles  = 0;
        error_count   = 0;
        send_idle_pct = 34;
        recv_idle_pct = 51;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // base 10 straight out of reset
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(32'hFFFF_FFFF);

        // base 2: longest digit strings, alternating bit patterns
        write_radix(5'd2);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);

        // base 16: letter digits
        write_radix(5'd16);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd15);
        pending_values.push_back(32'd16);
        pending_values.push_back(32'hFEDC_BA98);

        // register below two saturates to base 2, above sixteen to base 16; then bases 3 and 15
        write_radix(5'd0);
        pending_values.push_back(32'd6);
        write_radix(5'd1);
        pending_values.push_back(32'd5);
        write_radix(5'd17);
        pending_values.push_back(32'd255);
        write_radix(5'd31);
        pending_values.push_back(32'hABCD_EF01);
        write_radix(5'd3);
        pending_values.push_back(32'hFFFF_FFFF);
        write_radix(5'd15);
        pending_values.push_back(32'd14);

        // random values, one radix per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_radix((p == RANDOM_PHASES - 1) ? RADIX_W'($urandom_range(0, 31))
                                                 : PHASE_RADIX[p]);
            if (p < 4) begin
                send_idle_pct = 34;
                recv_idle_pct = 51;
            end else if (p < 8) begin
                send_idle_pct = 51;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // in phase 10 the sender pauses halfway until every digit is back
                if (p == 10 && i == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                pending_values.push_back(random_value());
            end
            if (p == 9) begin
                hold_armed = 1'b1;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_digits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== radix_digit_converter_top.f =====
src/rdc_pkg.sv
src/rdc_if.sv
src/rdc_div_step.sv
src/radix_digit_converter_top.sv
sim/tb.sv
